[hdl/acr_pkg.sv]
// Shared types and constants for the alpha coverage rescale block.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps
`default_nettype none
package acr_pkg;

  localparam int FIELDS           = 4;
  localparam int DEF_TILE_TEXELS  = 256;
  localparam int DEF_LANES        = 4;
  localparam int DEF_BISECT_STEPS = 16;

  localparam logic [16:0] SCALE_TOP  = 17'd65536;
  localparam logic [16:0] SCALE_ONE  = 17'd8192;
  localparam logic [24:0] KEEP_LEVEL = 25'd1044480;
  localparam logic [25:0] ROUND_HALF = 26'd4096;
  localparam logic [12:0] ALPHA_MAX  = 13'd255;

  typedef struct packed {
    logic [31:0] texel_a;
    logic [31:0] texel_b;
    logic [31:0] texel_c;
    logic [31:0] texel_d;
    logic [2:0]  texel_count;
    logic        tile_end;
    logic [16:0] target_coverage;
  } in_item_t;

  typedef struct packed {
    logic [31:0] scaled_a;
    logic [31:0] scaled_b;
    logic [31:0] scaled_c;
    logic [31:0] scaled_d;
    logic [2:0]  scaled_count;
    logic        scaled_end;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic add;
  } merge_ctl_t;

endpackage
`default_nettype wire

[hdl/acr_lane.sv]
// One texel lane: threshold test and alpha rescale from one multiply.
// Depends on acr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acr_lane
  import acr_pkg::*;
(
  input  wire logic [31:0] texel,
  input  wire logic [16:0] scale,
  output logic             hit,
  output logic [31:0]      scaled
);

  logic [24:0] prod;
  logic [25:0] rnd;
  logic [12:0] alpha_new;

  assign prod      = {17'd0, texel[31:24]} * scale;
  assign hit       = (prod >= KEEP_LEVEL);
  assign rnd       = {1'b0, prod} + ROUND_HALF;
  assign alpha_new = (rnd[25:13] > ALPHA_MAX) ? ALPHA_MAX : rnd[25:13];
  assign scaled    = {alpha_new[7:0], texel[23:0]};

endmodule
`default_nettype wire

[hdl/acr_merge.sv]
// Merge stage: counts lane hits and accumulates the kept count of one pass.
// Depends on acr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acr_merge
  import acr_pkg::*;
#(
  parameter int LN    = 4,
  parameter int CNT_W = 9
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire merge_ctl_t      ctl,
  input  wire logic [LN-1:0]   hits,
  output logic [CNT_W-1:0]     kept
);

  logic [CNT_W-1:0] kept_r;
  logic [CNT_W-1:0] kept_nxt;
  logic [CNT_W-1:0] pop;

  always_comb begin
    pop = '0;
    for (int l = 0; l < LN; l++) begin
      pop = pop + CNT_W'(hits[l]);
    end
  end

  always_comb begin
    kept_nxt = kept_r;
    if (ctl.clear) begin
      kept_nxt = '0;
    end else if (ctl.add) begin
      kept_nxt = kept_r + pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= '0;
    end else begin
      kept_r <= kept_nxt;
    end
  end

  assign kept = kept_r;

endmodule
`default_nettype wire

[hdl/alpha_coverage_rescale.sv]
// Top level of the alpha coverage rescale block.
// Depends on acr_pkg, acr_lane and acr_merge.
//
// Usage:
//   in_valid/in_ready/in_data carry requests of up to four RGBA texels. Groups
//   are stored until the request marked tile_end; its target_coverage is
//   sampled then. out_valid/out_ready/out_data return one result per stored
//   group, in order, the last one marked scaled_end.
// Timing:
//   Requests are accepted while loading. On tile_end the target product is
//   formed, then BISECT_STEPS passes run; each pass reads the G stored
//   groups through the single store read port, one group a cycle, then
//   drains the pipeline and updates the error before the next pass.
//   A zero target skips the search. Emit then reads each group from the
//   store and rescales it into the output register.
// Reset and stalls:
//   rst_n clears all control state; the store holds no valid bits, only
//   groups written in the current tile are read. While the receiver stalls,
//   emission holds; in_ready is high only while loading, and the block takes
//   the next tile while its last result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module alpha_coverage_rescale
  import acr_pkg::*;
#(
  parameter int TILE_TEXELS  = DEF_TILE_TEXELS,
  parameter int LANES        = DEF_LANES,
  parameter int BISECT_STEPS = DEF_BISECT_STEPS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int LANE_USE = (LANES < FIELDS) ? LANES : FIELDS;
  localparam int GROUPS   = TILE_TEXELS / LANES;
  localparam int AW       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW       = $clog2(GROUPS + 1);
  localparam int TW       = $clog2(TILE_TEXELS + 1);
  localparam int EW       = TW + 18;
  localparam int SW       = (BISECT_STEPS > 1) ? $clog2(BISECT_STEPS) : 1;

  typedef enum logic [2:0] {
    S_LOAD, S_MUL, S_SWEEP, S_ERR, S_UPD, S_EMIT_RD, S_EMIT_WAIT
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  gc_r;
  logic [TW-1:0]  total_r;
  logic [2:0]     last_valid_r;
  logic [16:0]    target_r;
  logic [16:0]    low_r;
  logic [16:0]    high_r;
  logic [16:0]    best_scale_r;
  logic [EW-1:0]  best_err_r;
  logic [EW-1:0]  want_r;
  logic [EW-1:0]  err_r;
  logic           lt_r;
  logic [SW-1:0]  step_r;
  logic [CW-1:0]  idx_r;

  // Tile store, one group of four texels per entry.
  logic [127:0]   store_mem [GROUPS];
  logic [127:0]   mem_q_r;
  logic           rdv_r;
  logic [2:0]     rcnt_r;
  logic [2:0]     vcnt_r;
  logic           hv_r;
  logic [LANE_USE-1:0] hits_r;

  logic           in_acc;
  logic           out_acc;
  logic           out_load;
  logic [2:0]     cnt;
  logic           rd_en;
  logic [2:0]     idx_vcnt;
  logic [17:0]    mid_sum;
  logic [16:0]    mid;
  logic [16:0]    lane_scale;
  logic [LANE_USE-1:0] hit_raw;
  logic [LANE_USE-1:0] hit_mask;
  logic [31:0]    lane_out [FIELDS];
  logic [TW-1:0]  kept;
  merge_ctl_t     mctl;
  logic [EW-1:0]  got;
  out_item_t      out_r;
  logic           out_valid_r;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  // Load the output register once it is free or being drained.
  assign out_load = (state_r == S_EMIT_WAIT) && (!out_valid_r || out_ready);

  // Saturate the count; inner groups are always full.
  always_comb begin
    cnt = (in_data.texel_count > 3'(LANE_USE)) ? 3'(LANE_USE) : in_data.texel_count;
    if (!in_data.tile_end) begin
      cnt = 3'(LANE_USE);
    end
  end

  assign mid_sum    = {1'b0, low_r} + {1'b0, high_r};
  assign mid        = mid_sum[17:1];
  assign lane_scale = (state_r == S_EMIT_WAIT) ? best_scale_r : mid;
  assign idx_vcnt   = (idx_r + CW'(1) == gc_r) ? last_valid_r : 3'(LANE_USE);
  assign rd_en      = ((state_r == S_SWEEP) && (idx_r < gc_r)) || (state_r == S_EMIT_RD);

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (in_acc && (gc_r < CW'(GROUPS))) begin
      store_mem[gc_r[AW-1:0]] <= {in_data.texel_d, in_data.texel_c,
                                  in_data.texel_b, in_data.texel_a};
    end
    if (rd_en) begin
      mem_q_r <= store_mem[idx_r[AW-1:0]];
      rcnt_r  <= idx_vcnt;
    end
  end

  // Lanes work side by side on the texels of the group just read.
  genvar gl;
  generate
    for (gl = 0; gl < FIELDS; gl++) begin : g_lane
      if (gl < LANE_USE) begin : g_on
        acr_lane u_lane (
          .texel  (mem_q_r[32*gl +: 32]),
          .scale  (lane_scale),
          .hit    (hit_raw[gl]),
          .scaled (lane_out[gl])
        );
        assign hit_mask[gl] = hit_raw[gl] && (3'(gl) < rcnt_r);
      end else begin : g_off
        assign lane_out[gl] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    hits_r <= hit_mask;
  end

  assign mctl.clear = (state_r == S_MUL) || (state_r == S_UPD);
  assign mctl.add   = hv_r;

  acr_merge #(.LN(LANE_USE), .CNT_W(TW)) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .hits  (hits_r),
    .kept  (kept)
  );

  assign got = EW'({kept, 16'd0});

  // Control, search state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      gc_r         <= '0;
      total_r      <= '0;
      last_valid_r <= '0;
      target_r     <= '0;
      low_r        <= '0;
      high_r       <= SCALE_TOP;
      best_scale_r <= SCALE_ONE;
      best_err_r   <= '1;
      step_r       <= '0;
      idx_r        <= '0;
      rdv_r        <= 1'b0;
      hv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rdv_r <= rd_en && (state_r == S_SWEEP);
      hv_r  <= rdv_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (gc_r < CW'(GROUPS)) begin
              gc_r         <= gc_r + CW'(1);
              last_valid_r <= cnt;
              total_r      <= total_r + TW'(cnt);
            end
            if (in_data.tile_end) begin
              target_r <= in_data.target_coverage;
              state_r  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          want_r <= EW'(target_r * total_r);
          idx_r  <= '0;
          // Zero target: skip the search, scale stays at one.
          state_r <= (target_r == '0) ? S_EMIT_RD : S_SWEEP;
        end
        S_SWEEP: begin
          if (idx_r < gc_r) begin
            idx_r <= idx_r + CW'(1);
          end else if (!rdv_r && !hv_r) begin
            state_r <= S_ERR;
          end
        end
        S_ERR: begin
          err_r   <= (got > want_r) ? (got - want_r) : (want_r - got);
          lt_r    <= (got < want_r);
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (err_r < best_err_r) begin
            best_err_r   <= err_r;
            best_scale_r <= mid;
          end
          if (lt_r) begin
            low_r <= mid;
          end else begin
            high_r <= mid;
          end
          idx_r <= '0;
          if (step_r == SW'(BISECT_STEPS - 1)) begin
            state_r <= S_EMIT_RD;
          end else begin
            step_r  <= step_r + SW'(1);
            state_r <= S_SWEEP;
          end
        end
        S_EMIT_RD: begin
          vcnt_r  <= idx_vcnt;
          state_r <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          // Hold the read group until the output register frees up.
          if (out_load) begin
            out_r.scaled_a        <= (3'd0 < vcnt_r) ? lane_out[0] : 32'd0;
            out_r.scaled_b        <= (3'd1 < vcnt_r) ? lane_out[1] : 32'd0;
            out_r.scaled_c        <= (3'd2 < vcnt_r) ? lane_out[2] : 32'd0;
            out_r.scaled_d        <= (3'd3 < vcnt_r) ? lane_out[3] : 32'd0;
            out_r.scaled_count    <= vcnt_r;
            out_r.scaled_end      <= (idx_r + CW'(1) == gc_r);
            if (idx_r + CW'(1) == gc_r) begin
              // Last group out: drop the tile and go back to loading.
              gc_r         <= '0;
              total_r      <= '0;
              last_valid_r <= '0;
              target_r     <= '0;
              low_r        <= '0;
              high_r       <= SCALE_TOP;
              best_scale_r <= SCALE_ONE;
              best_err_r   <= '1;
              step_r       <= '0;
              idx_r        <= '0;
              state_r      <= S_LOAD;
            end else begin
              idx_r   <= idx_r + CW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gc_r <= CW'(GROUPS))
    else $error("group count beyond store depth");

  a_interval: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= high_r)
    else $error("search interval inverted");

  a_inner_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.scaled_end) |-> (state_r != S_LOAD))
    else $error("inner result left while loading");

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.scaled_count <= 3'(LANE_USE)))
    else $error("result count above lane count");

endmodule
`default_nettype wire

[verif/tb_alpha_coverage_rescale.sv]
// Self-checking testbench for alpha_coverage_rescale: drives tiles of texel requests,
// predicts the rescaled tiles with a bit-exact coverage search and checks every result.
// Depends on acr_pkg and the RTL in hdl/.
`timescale 1ns / 1ps
module tb_alpha_coverage_rescale;
  import acr_pkg::*;

  localparam int TILE_TEXELS  = 256;
  localparam int LANES        = 4;
  localparam int BISECT_STEPS = 16;
  localparam int GROUPS       = TILE_TEXELS / LANES;
  localparam int LANE_USE     = (LANES < FIELDS) ? LANES : FIELDS;
  localparam logic [29:0] ERR_ONES = 30'h3FFF_FFFF;
  localparam int IDLE_LIMIT   = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  alpha_coverage_rescale #(
    .TILE_TEXELS(TILE_TEXELS), .LANES(LANES), .BISECT_STEPS(BISECT_STEPS)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: the tile being collected.
  logic [31:0] tile_texels [GROUPS][FIELDS];
  int unsigned stored_groups;
  int unsigned texel_sum;
  int unsigned final_valid;

  out_item_t   scaled_queue[$];
  int          errors;
  int          idle_cycles;
  bit          rx_enable;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Return a random gap: mostly short, sometimes long, often none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned lane_valid(int unsigned g);
    return (g + 1 == stored_groups) ? final_valid : LANE_USE;
  endfunction

  function automatic int unsigned kept_at(logic [16:0] scale);
    int unsigned kept;
    logic [40:0] prod;
    kept = 0;
    for (int unsigned g = 0; g < stored_groups; g++)
      for (int unsigned l = 0; l < lane_valid(g); l++) begin
        prod = tile_texels[g][l][31:24] * scale;
        if (prod >= KEEP_LEVEL) kept++;
      end
    return kept;
  endfunction

  function automatic logic [31:0] rescale_texel(logic [31:0] t, logic [16:0] scale);
    logic [40:0] a;
    a = (t[31:24] * scale + 41'd4096) >> 13;
    if (a > 255) a = 255;
    return {a[7:0], t[23:0]};
  endfunction

  // Fold one accepted request into the tile; on tile end push the whole rescaled tile.
  task automatic predict_request(in_item_t req);
    int unsigned cnt;
    logic [16:0] target, lo, hi, mid, best_scale;
    logic [63:0] want, got, diff;
    logic [29:0] best_err;
    logic [31:0] t;
    out_item_t   res;
    cnt = (req.texel_count > LANE_USE) ? LANE_USE : req.texel_count;
    if (!req.tile_end) cnt = LANE_USE;
    if (stored_groups < GROUPS) begin
      tile_texels[stored_groups] = '{req.texel_a, req.texel_b, req.texel_c, req.texel_d};
      stored_groups++;
      final_valid = cnt;
      texel_sum += cnt;
    end
    if (!req.tile_end) return;
    target = req.target_coverage;
    best_scale = SCALE_ONE;
    if (target != 0) begin
      lo = 0; hi = SCALE_TOP; best_err = ERR_ONES;
      want = 64'(target) * texel_sum;
      for (int s = 0; s < BISECT_STEPS; s++) begin
        mid = 17'((18'(lo) + 18'(hi)) >> 1);
        got = 64'(kept_at(mid)) << 16;
        diff = (got > want) ? got - want : want - got;
        if (diff < 64'(best_err)) begin
          best_err = diff[29:0];
          best_scale = mid;
        end
        if (got < want) lo = mid; else hi = mid;
      end
    end
    for (int unsigned g = 0; g < stored_groups; g++) begin
      logic [31:0] lanes_out [FIELDS];
      for (int l = 0; l < FIELDS; l++) begin
        t = tile_texels[g][l];
        lanes_out[l] = (l < lane_valid(g)) ? ((target == 0) ? t : rescale_texel(t, best_scale))
                                           : 32'd0;
      end
      res.scaled_a = lanes_out[0];
      res.scaled_b = lanes_out[1];
      res.scaled_c = lanes_out[2];
      res.scaled_d = lanes_out[3];
      res.scaled_count = 3'(lane_valid(g));
      res.scaled_end = (g + 1 == stored_groups);
      scaled_queue.push_back(res);
    end
    stored_groups = 0;
    texel_sum = 0;
    final_valid = 0;
  endtask

  // Send one request: raise valid at a falling edge, hold until accepted.
  // Valid drops only when a gap follows; the caller drops it after the last request.
  task automatic send_request(in_item_t req);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_request(req);
    @(negedge clk);
  endtask

  // Receiver: random backpressure, changed at the falling edge.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = 0;
      if (rx_enable && ($urandom_range(0, 99) < 8)) stall = gap_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (scaled_queue.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        out_item_t exp_res;
        exp_res = scaled_queue.pop_front();
        if (out_data.scaled_a !== exp_res.scaled_a) begin
          $error("scaled_a exp %h got %h", exp_res.scaled_a, out_data.scaled_a); errors++;
        end
        if (out_data.scaled_b !== exp_res.scaled_b) begin
          $error("scaled_b exp %h got %h", exp_res.scaled_b, out_data.scaled_b); errors++;
        end
        if (out_data.scaled_c !== exp_res.scaled_c) begin
          $error("scaled_c exp %h got %h", exp_res.scaled_c, out_data.scaled_c); errors++;
        end
        if (out_data.scaled_d !== exp_res.scaled_d) begin
          $error("scaled_d exp %h got %h", exp_res.scaled_d, out_data.scaled_d); errors++;
        end
        if (out_data.scaled_count !== exp_res.scaled_count) begin
          $error("scaled_count exp %0d got %0d", exp_res.scaled_count, out_data.scaled_count);
          errors++;
        end
        if (out_data.scaled_end !== exp_res.scaled_end) begin
          $error("scaled_end exp %0d got %0d", exp_res.scaled_end, out_data.scaled_end);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("alpha_coverage_rescale regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_texel();
    return $urandom();
  endfunction

  function automatic in_item_t make_req(bit last, logic [2:0] cnt, logic [16:0] target);
    in_item_t r;
    r.texel_a = rand_texel(); r.texel_b = rand_texel();
    r.texel_c = rand_texel(); r.texel_d = rand_texel();
    r.texel_count = cnt; r.tile_end = last; r.target_coverage = target;
    return r;
  endfunction

  // Send a tile of inner groups followed by its closing group.
  task automatic send_tile(int inner, logic [2:0] cnt, logic [16:0] target);
    for (int i = 0; i < inner; i++)
      send_request(make_req(1'b0, 3'($urandom_range(0, 7)), 17'($urandom())));
    send_request(make_req(1'b1, cnt, target));
  endtask

  // Extremes: alpha 0/255, target 0, 1.0 and out of range, single-group and short multi-group tiles.
  task automatic test_directed_extremes();
    in_item_t r;
    r = make_req(1'b1, 3'd4, 17'd65536);
    r.texel_a = 32'h0000_0000; r.texel_b = 32'hFFFF_FFFF;
    r.texel_c = 32'h80AA_55AA; r.texel_d = 32'h7F12_3456;
    send_request(r);
    r.target_coverage = 17'd0; send_request(r);
    r.target_coverage = 17'h1FFFF; send_request(r);
    r.target_coverage = 17'd1; send_request(r);
    r.target_coverage = 17'd32768; send_request(r);
    send_tile(2, 3'd0, 17'd30000);   // zero count on the closing group
    send_tile(1, 3'd7, 17'd40000);   // count saturates to the lane count
    send_tile(3, 3'd1, 17'd0);       // pass-through with inner groups
    send_tile(2, 3'd3, 17'd65536);
  endtask

  // Overflow the store so that the closing group is dropped, then fill it exactly.
  task automatic test_store_full();
    send_tile(GROUPS, 3'd2, 17'd20000);
    send_tile(GROUPS - 1, 3'd2, 17'd50000);
  endtask

  // Random tiles, mostly small, with random content and targets.
  task automatic test_random_tiles();
    int sent;
    int inner;
    logic [16:0] target;
    sent = 0;
    while (sent < 270) begin
      inner = ($urandom_range(0, 19) == 0) ? $urandom_range(20, GROUPS + 1)
                                            : $urandom_range(0, 6);
      case ($urandom_range(0, 5))
        0: target = 17'd0;
        1: target = 17'd65536;
        2: target = 17'($urandom_range(65537, 131071));
        default: target = 17'($urandom_range(1, 65535));
      endcase
      send_tile(inner, 3'($urandom_range(0, 7)), target);
      sent += inner + 1;
    end
  endtask

  initial begin
    errors = 0; idle_cycles = 0; rx_enable = 0;
    stored_groups = 0; texel_sum = 0; final_valid = 0;
    in_valid = 1'b0; in_data = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    rx_enable = 1;
    test_store_full();
    test_random_tiles();
    in_valid <= 1'b0;
    // Drain: wait for every predicted result, then a short settle.
    while (scaled_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("alpha_coverage_rescale regression: pass");
    else $display("alpha_coverage_rescale regression: fail");
    $finish;
  end
endmodule
